>>> hdl/tirt_pkg.sv
// ----------------------------------------------------------------------------
// tirt_pkg
// Shared types and constants of the interpolated resistance table: item and
// result payloads, command codes, controller/datapath signal groups.
// ----------------------------------------------------------------------------
package tirt_pkg;

	// default table geometry
	localparam int TEMP_POINTS_DEF = 8;
	localparam int ROW_ENTRIES_DEF = 32;

	// configuration register indexes
	localparam logic CFG_BREAKPOINT_COUNT = 1'b0;
	localparam logic CFG_ROW_LENGTH       = 1'b1;

	// configuration reset values
	localparam logic [3:0] BREAKPOINT_COUNT_RST = 4'd8;
	localparam logic [5:0] ROW_LENGTH_RST       = 6'd32;

	localparam logic [23:0] RES_MAX = 24'hFF_FFFF;

	typedef enum logic [1:0] {
		CMD_LOAD_TEMP = 2'd0,
		CMD_LOAD_RES  = 2'd1,
		CMD_QUERY     = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic [2:0]         point_index;
		logic [4:0]         entry_index;
		logic signed [15:0] temperature;
		logic [23:0]        resistance_value;
	} item_t;

	typedef struct packed {
		logic [4:0]  out_index;
		logic [23:0] resistance;
		logic        last;
	} result_t;

	// controller commands to the datapath
	typedef struct packed {
		logic load_temp;
		logic load_res;
		logic q_start;
		logic scan_step;
		logic rd;
		logic mul;
		logic prep;
		logic div_step;
		logic fin;
		logic advance;
	} ctrl_t;

	// datapath status to the controller
	typedef struct packed {
		logic scan_stop;
		logic copy;
		logic div_last;
		logic entry_last;
	} status_t;

endpackage

>>> hdl/tirt_ctrl.sv
// ----------------------------------------------------------------------------
// tirt_ctrl
// Sequencer: decodes accepted items, walks the breakpoint scan, then runs
// each row entry through read, multiply, divide (copied rows skip it), output.
// ----------------------------------------------------------------------------
module tirt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tirt_pkg::cmd_t  command,
	input  tirt_pkg::status_t status,
	output tirt_pkg::ctrl_t ctrl,
	output logic            busy,
	output logic            strobe
);
	import tirt_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_SCAN = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_MUL  = 8'b0000_1000,
		S_PREP = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign strobe = (state_q == S_OUT);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctrl.load_temp = (command == CMD_LOAD_TEMP);
					ctrl.load_res  = (command == CMD_LOAD_RES);
					ctrl.q_start   = (command == CMD_QUERY);
					if (command == CMD_QUERY) state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				ctrl.scan_step = 1'b1;
				if (status.scan_stop) state_d = S_RD;
			end
			S_RD: begin
				ctrl.rd = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = status.copy ? S_OUT : S_PREP;
			end
			S_PREP: begin
				ctrl.prep = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (status.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				ctrl.fin = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				ctrl.advance = 1'b1;
				state_d      = status.entry_last ? S_IDLE : S_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

>>> hdl/tirt_datapath.sv
// ----------------------------------------------------------------------------
// tirt_datapath
// Breakpoint and row storage, configuration registers, scan counter,
// multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
module tirt_datapath #(
	parameter int TEMP_POINTS = tirt_pkg::TEMP_POINTS_DEF,
	parameter int ROW_ENTRIES = tirt_pkg::ROW_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tirt_pkg::item_t   item,
	input  tirt_pkg::ctrl_t   ctrl,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [5:0]        cfg_data,
	output tirt_pkg::status_t status,
	output tirt_pkg::result_t result
);
	import tirt_pkg::*;

	localparam int TW    = $clog2(TEMP_POINTS);
	localparam int CW    = $clog2(TEMP_POINTS + 1);
	localparam int LW    = $clog2(ROW_ENTRIES + 1);
	localparam int DEPTH = TEMP_POINTS * ROW_ENTRIES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int QW    = 25;
	localparam int DCW   = $clog2(QW);

	// configuration registers
	logic [3:0] cnt_cfg_q;
	logic [5:0] len_cfg_q;
	logic [CW-1:0] cnt_eff;
	logic [LW-1:0] len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q <= BREAKPOINT_COUNT_RST;
			len_cfg_q <= ROW_LENGTH_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BREAKPOINT_COUNT) cnt_cfg_q <= cfg_data[3:0];
			if (cfg_index == CFG_ROW_LENGTH)       len_cfg_q <= cfg_data;
		end
	end

	// clamp counts into the table geometry
	always_comb begin
		if (cnt_cfg_q == 4'd0)                    cnt_eff = CW'(1);
		else if (int'(cnt_cfg_q) > TEMP_POINTS)   cnt_eff = CW'(TEMP_POINTS);
		else                                      cnt_eff = CW'(cnt_cfg_q);
		if (len_cfg_q == 6'd0)                    len_eff = LW'(1);
		else if (int'(len_cfg_q) > ROW_ENTRIES)   len_eff = LW'(ROW_ENTRIES);
		else                                      len_eff = LW'(len_cfg_q);
	end

	// breakpoint storage, one read place
	logic [15:0] bt_q [TEMP_POINTS];
	logic [TW-1:0] i_q;
	logic signed [15:0] bt_rd;

	assign bt_rd = bt_q[i_q];

	always_ff @(posedge clk) begin
		if (ctrl.load_temp && int'(item.point_index) < TEMP_POINTS)
			bt_q[TW'(item.point_index)] <= item.temperature;
	end

	// row memory, one write and two read ports
	logic [23:0] mem [DEPTH];
	logic [23:0] rd_lo_q, rd_hi_q;
	logic [TW-1:0] row_q;
	logic [LW-1:0] e_q;
	logic copy_q;
	logic [AW-1:0] wr_addr, lo_addr, hi_addr;

	assign wr_addr = AW'(int'(item.point_index) * ROW_ENTRIES + int'(item.entry_index));
	assign lo_addr = AW'(int'(row_q) * ROW_ENTRIES + int'(e_q));
	assign hi_addr = copy_q ? lo_addr
	                        : AW'((int'(row_q) + 1) * ROW_ENTRIES + int'(e_q));

	always_ff @(posedge clk) begin
		if (ctrl.load_res && int'(item.point_index) < TEMP_POINTS
		    && int'(item.entry_index) < ROW_ENTRIES)
			mem[wr_addr] <= item.resistance_value;
		if (ctrl.rd) begin
			rd_lo_q <= mem[lo_addr];
			rd_hi_q <= mem[hi_addr];
		end
	end

	// breakpoint scan from the top
	logic signed [15:0] temp_q, prev_q, tlo_q, thi_q;
	logic hit;

	assign hit              = temp_q > bt_rd;
	assign status.scan_stop = hit || (i_q == '0);
	assign status.copy      = copy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			row_q  <= '0;
			copy_q <= 1'b0;
			e_q    <= '0;
		end else begin
			if (ctrl.q_start) begin
				i_q <= TW'(cnt_eff - CW'(1));
				e_q <= '0;
			end
			if (ctrl.scan_step) begin
				if (status.scan_stop) begin
					copy_q <= !hit || (i_q == TW'(cnt_eff - CW'(1)));
					row_q  <= hit ? i_q : '0;
				end else begin
					i_q <= i_q - TW'(1);
				end
			end
			if (ctrl.advance) e_q <= e_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.q_start) temp_q <= item.temperature;
		if (ctrl.scan_step) begin
			prev_q <= bt_rd;
			tlo_q  <= bt_rd;
			thi_q  <= prev_q;
		end
	end

	// multiply step: |hi - lo| times offset into the interval
	logic [24:0] diff;
	logic [23:0] mag;
	logic [16:0] dt, den;
	logic [40:0] prod_q;
	logic [16:0] den_q;
	logic        neg_q;

	assign diff = {1'b0, rd_hi_q} - {1'b0, rd_lo_q};
	assign mag  = diff[24] ? 24'(-diff) : diff[23:0];
	assign dt   = {temp_q[15], temp_q} - {tlo_q[15], tlo_q};
	assign den  = {thi_q[15], thi_q} - {tlo_q[15], tlo_q};

	// restoring divider, one quotient bit a cycle
	logic [41:0] dvd;
	logic [16:0] rem_q;
	logic [QW-1:0] qd_q;
	logic [DCW-1:0] dcnt_q;
	logic [17:0] trial;
	logic        fits;
	logic [25:0] sum;
	logic [23:0] res_q;

	assign dvd   = {1'b0, prod_q} + 42'(den_q >> 1);
	assign trial = {rem_q, qd_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign sum   = neg_q ? ({2'b00, rd_lo_q} - {1'b0, qd_q})
	                     : ({2'b00, rd_lo_q} + {1'b0, qd_q});

	assign status.div_last = (dcnt_q == DCW'(QW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (ctrl.prep) dcnt_q <= '0;
		else if (ctrl.div_step) dcnt_q <= dcnt_q + DCW'(1);
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= mag * dt;
			den_q  <= den;
			neg_q  <= diff[24];
			if (copy_q) res_q <= rd_lo_q;
		end
		if (ctrl.prep) begin
			rem_q <= dvd[41:QW];
			qd_q  <= dvd[QW-1:0];
		end
		if (ctrl.div_step) begin
			rem_q <= fits ? 17'(trial - {1'b0, den_q}) : trial[16:0];
			qd_q  <= {qd_q[QW-2:0], fits};
		end
		if (ctrl.fin) begin
			if (sum[25])      res_q <= '0;
			else if (sum[24]) res_q <= RES_MAX;
			else              res_q <= sum[23:0];
		end
	end

	// result fields
	assign status.entry_last = (e_q == LW'(len_eff - LW'(1)));
	assign result.out_index  = 5'(e_q);
	assign result.resistance = res_q;
	assign result.last       = status.entry_last;

endmodule

>>> hdl/temp_interpolated_resistance_table.sv
// ----------------------------------------------------------------------------
// temp_interpolated_resistance_table
// Resistance versus temperature table with piecewise-linear interpolation.
// ----------------------------------------------------------------------------
// A query scans breakpoints one per cycle from the top (up to breakpoint_count),
// then reads, multiplies and outputs each emitted entry when a row is copied,
// adding a prep step, the one-bit-a-cycle divider (25 steps) and a finish step
// when interpolated. busy is high for the whole query; each result beat sits
// on result for one cycle under result_strobe and must be taken then, as the
// receiver cannot stall. Configuration writes are always ready and belong to idle periods.
// ----------------------------------------------------------------------------
module temp_interpolated_resistance_table #(
	parameter int TEMP_POINTS = tirt_pkg::TEMP_POINTS_DEF,
	parameter int ROW_ENTRIES = tirt_pkg::ROW_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tirt_pkg::item_t   item,
	output logic              result_strobe,
	output tirt_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [5:0]        cfg_data
);
	import tirt_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	tirt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (item.command),
		.status  (status),
		.ctrl    (ctrl),
		.busy    (busy),
		.strobe  (result_strobe)
	);

	// storage and arithmetic
	tirt_datapath #(
		.TEMP_POINTS (TEMP_POINTS),
		.ROW_ENTRIES (ROW_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ctrl      (ctrl),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result)
	);

	// a query beat starts a busy run
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command == CMD_QUERY |=> busy)
		else $error("query accepted but block not busy");

	// the last beat ends the run
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !busy)
		else $error("still busy after last beat");

	// beats never come in consecutive cycles
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back-to-back result beats");

	// loads never start a run
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command != CMD_QUERY |=> !busy)
		else $error("load made block busy");

endmodule

>>> tb/sv/tb_temp_interpolated_resistance_table.sv
// ----------------------------------------------------------------------------
// tb_temp_interpolated_resistance_table
// Self-checking bench for the interpolated resistance table: fills the whole
// table, then runs queries and loads under several breakpoint/row settings
// with random start gaps and checks every result beat against a predictor.
// ----------------------------------------------------------------------------
module tb_temp_interpolated_resistance_table;
	import tirt_pkg::*;

	localparam int NPTS = TEMP_POINTS_DEF;
	localparam int NENT = ROW_ENTRIES_DEF;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	item_t          item = '0;
	logic           result_strobe;
	result_t        result;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic           cfg_index = CFG_BREAKPOINT_COUNT;
	logic [5:0]     cfg_data = '0;

	temp_interpolated_resistance_table uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [15:0] pred_temps [NPTS];
	logic [23:0]        pred_rows [NPTS*NENT];
	logic [3:0]         pred_count = BREAKPOINT_COUNT_RST;
	logic [5:0]         pred_len = ROW_LENGTH_RST;

	result_t     expected_beats [$];
	item_t       pending_items [$];
	int          acc_cnt = 0;
	int          issued = 0;
	int          gap = 0;
	bit          no_idle = 1'b0;
	bit          failed = 1'b0;
	logic signed [15:0] gen_temps [NPTS];

	// clock and reset
	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// expected beats of one accepted item
	function automatic void predict_table(item_t it);
		int cnt, len, i, e;
		longint lo, hi, tlo, thi, den, num, q, r;
		result_t rb;
		case (it.command)
			CMD_LOAD_TEMP: pred_temps[it.point_index] = it.temperature;
			CMD_LOAD_RES:  pred_rows[it.point_index*NENT + it.entry_index] =
				it.resistance_value;
			CMD_QUERY: begin
				cnt = (pred_count == 0) ? 1 : (pred_count > NPTS) ? NPTS : pred_count;
				len = (pred_len == 0) ? 1 : (pred_len > NENT) ? NENT : pred_len;
				for (i = cnt - 1; i >= 0; i--)
					if (it.temperature > pred_temps[i]) break;
				for (e = 0; e < len; e++) begin
					if (i == cnt - 1) begin
						r = pred_rows[(cnt-1)*NENT + e];
					end else if (i < 0) begin
						r = pred_rows[e];
					end else begin
						lo  = pred_rows[i*NENT + e];
						hi  = pred_rows[(i+1)*NENT + e];
						tlo = pred_temps[i];
						thi = pred_temps[i+1];
						den = thi - tlo;
						if (den <= 0) den = 1;
						num = (hi - lo) * (longint'(it.temperature) - tlo);
						q = (num > 0) ? (num + den/2) / den : (num - den/2) / den;
						r = lo + q;
						if (r < 0) r = 0;
						if (r > RES_MAX) r = RES_MAX;
					end
					rb.out_index  = e[4:0];
					rb.resistance = r[23:0];
					rb.last       = (e == len - 1);
					expected_beats.push_back(rb);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 50) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// driver: start beats from the pending queue, changed on falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && acc_cnt != issued)) begin
			if (gap != 0) begin
				start <= 1'b0;
				gap <= gap - 1;
			end else if (pending_items.size() != 0) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
				issued <= issued + 1;
				gap <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: accepted items, config writes, result beats
	always @(posedge clk) begin
		result_t ex;
		if (arst_n) begin
			if (start && !busy) begin
				predict_table(item);
				acc_cnt <= acc_cnt + 1;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BREAKPOINT_COUNT) pred_count <= cfg_data[3:0];
				else pred_len <= cfg_data;
			end
			if (result_strobe) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat index=%0d res=%0h",
						result.out_index, result.resistance);
					failed = 1'b1;
				end else begin
					ex = expected_beats.pop_front();
					if (result.out_index !== ex.out_index) begin
						$error("out_index exp %0d got %0d", ex.out_index, result.out_index);
						failed = 1'b1;
					end
					if (result.resistance !== ex.resistance) begin
						$error("resistance exp %0h got %0h", ex.resistance, result.resistance);
						failed = 1'b1;
					end
					if (result.last !== ex.last) begin
						$error("last exp %0b got %0b", ex.last, result.last);
						failed = 1'b1;
					end
				end
			end
		end
	end

	task automatic push_item(cmd_t c, int pt, int ent, int t, int rv);
		item_t it;
		it.command          = c;
		it.point_index      = pt[2:0];
		it.entry_index      = ent[4:0];
		it.temperature      = t[15:0];
		it.resistance_value = rv[23:0];
		if (c == CMD_LOAD_TEMP) gen_temps[pt[2:0]] = t[15:0];
		pending_items.push_back(it);
	endtask

	// wait until everything sent is answered and the block is quiet
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || start || busy || expected_beats.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, int val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val[5:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_sorted_temps();
		int t, k;
		t = -32768 + $urandom_range(1000);
		for (k = 0; k < NPTS; k++) begin
			push_item(CMD_LOAD_TEMP, k, $urandom_range(31), t, $urandom);
			t += $urandom_range(8000, 1);
		end
	endtask

	function automatic int query_temp();
		int r, t;
		r = $urandom_range(9);
		if (r < 2) return $urandom_range(65535) - 32768;
		t = gen_temps[$urandom_range(NPTS-1)];
		if (r < 4) return t;
		t = t + $urandom_range(4000) - 2000;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t;
	endfunction

	task automatic random_phase(int n);
		int k, r;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 70)
				push_item(CMD_QUERY, $urandom_range(7), $urandom_range(31),
					query_temp(), $urandom);
			else if (r < 85)
				push_item(CMD_LOAD_RES, $urandom_range(7), $urandom_range(31),
					$urandom_range(65535), $urandom);
			else if (r < 92)
				push_item(CMD_LOAD_TEMP, $urandom_range(7), $urandom_range(31),
					query_temp(), $urandom);
			else begin
				push_item(CMD_QUERY, 0, 0, 0, 0);
				pending_items[pending_items.size()-1].command = cmd_t'(2'd3);
				pending_items[pending_items.size()-1].temperature = 16'($urandom);
				pending_items[pending_items.size()-1].resistance_value = 24'($urandom);
			end
		end
	endtask

	// stimulus sequence
	initial begin
		int p, e, k;
		int bp_set [NPTS] = '{-32768, -1000, -10, 0, 5, 300, 2000, 32767};
		int cnts [7] = '{8, 1, 0, 15, 3, 2, 8};
		int lens [7] = '{5, 1, 0, 63, 32, 17, 32};
		@(posedge arst_n);

		// fill the whole table first so no read hits an unwritten entry
		no_idle = 1'b1;
		for (p = 0; p < NPTS; p++)
			push_item(CMD_LOAD_TEMP, p, 0, bp_set[p], 0);
		for (p = 0; p < NPTS; p++)
			for (e = 0; e < NENT; e++)
				push_item(CMD_LOAD_RES, p, e, 0,
					(p == 0 && e == 0) ? 0 : (p == 7 && e == 0) ? 24'hFF_FFFF : $urandom);
		drain();
		no_idle = 1'b0;

		// directed: extremes, breakpoint hits, in-between, ignored code
		push_item(CMD_QUERY, 0, 0, -32768, 0);
		push_item(CMD_QUERY, 7, 31, 32767, 24'hFF_FFFF);
		push_item(CMD_QUERY, 0, 0, -1000, 0);
		push_item(CMD_QUERY, 0, 0, -999, 0);
		push_item(CMD_QUERY, 0, 0, 1, 0);
		push_item(CMD_QUERY, 0, 0, 4, 0);
		push_item(CMD_QUERY, 0, 0, 1999, 0);
		push_item(CMD_QUERY, 0, 0, 32766, 0);
		push_item(CMD_LOAD_RES, 3, 2, 0, 24'hFF_FFFF);
		push_item(CMD_LOAD_RES, 4, 2, 0, 0);
		push_item(CMD_QUERY, 0, 0, 3, 0);
		push_item(CMD_QUERY, 0, 0, 0, 0);
		push_item(CMD_QUERY, 0, 0, 0, 0);
		pending_items[pending_items.size()-1].command = cmd_t'(2'd3);
		push_item(CMD_QUERY, 0, 0, 150, 0);
		drain();

		// random phases under several settings, extremes included
		for (k = 0; k < 7; k++) begin
			write_cfg(CFG_BREAKPOINT_COUNT, cnts[k]);
			write_cfg(CFG_ROW_LENGTH, lens[k]);
			if (k % 2 == 1) load_sorted_temps();
			no_idle = (k == 4);
			random_phase(22);
			drain();
		end

		if (!failed)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hdl/tirt_pkg.sv
hdl/tirt_ctrl.sv
hdl/tirt_datapath.sv
hdl/temp_interpolated_resistance_table.sv
tb/sv/tb_temp_interpolated_resistance_table.sv
